### hw/rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Shared types and constants of the band interleave reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package bir_pkg;

    localparam int PIX_W       = 13;
    localparam int BND_W       = 5;
    localparam int DPIX_W      = 12;
    localparam int DBND_W      = 4;
    localparam int SMP_W       = 16;
    localparam int BLEN_W      = 17;
    localparam int X_W         = 17;
    localparam int PIX_MAX     = 8191;
    localparam int BND_MAX     = 31;
    localparam int RST_PIXELS  = 1024;
    localparam int RST_BANDS   = 3;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_PIXELS = 2'd0,
        CFG_BANDS  = 2'd1,
        CFG_DIR    = 2'd2
    } t_cfg_idx;

    // effective block sizes, already clamped
    typedef struct packed {
        logic [BLEN_W-1:0] blen;
        logic [PIX_W-1:0]  pixels;
        logic [BND_W-1:0]  bands;
        logic              dir;
    } t_cfg;

    // one request on its way through address calculation and memory access
    typedef struct packed {
        logic              emit;
        logic              drop;
        logic              last;
        logic [DBND_W-1:0] band;
        logic [PIX_W-1:0]  mul_a;
        logic [BND_W-1:0]  mul_m;
        logic [DPIX_W-1:0] mul_c;
        logic              rd_bank;
        logic              wr_en;
        logic              wr_bank;
        logic [PIX_W-1:0]  wr_pos;
        logic [SMP_W-1:0]  wr_data;
    } t_tok;

endpackage

`default_nettype wire

### hw/rtl/bir_in_if.sv
// ----------------------------------------------------------------------------
// bir_in_if
// Input request channel: push or drain tick with one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bir_in_if import bir_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [SMP_W-1:0] sample_in;

    modport source (output valid, output op, output sample_in, input ready);
    modport sink   (input valid, input op, input sample_in, output ready);
endinterface

`default_nettype wire

### hw/rtl/bir_out_if.sv
// ----------------------------------------------------------------------------
// bir_out_if
// Output request channel: one reordered sample with its tags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bir_out_if import bir_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  sample_out;
    logic [DBND_W-1:0] band_out;
    logic              block_end;
    logic              dropped;

    modport source (output valid, output sample_out, output band_out,
                    output block_end, output dropped, input ready);
    modport sink   (input valid, input sample_out, input band_out,
                    input block_end, input dropped, output ready);
endinterface

`default_nettype wire

### hw/rtl/bir_cfg.sv
// ----------------------------------------------------------------------------
// bir_cfg
// Configuration registers and clamped block sizes, updated on the write.
// ----------------------------------------------------------------------------
`default_nettype none

module bir_cfg import bir_pkg::*; #(
    parameter int BANK_SAMPLES = 4096,
    parameter int MAX_BANDS    = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [PIX_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    localparam int BMAX     = (MAX_BANDS < BND_MAX) ? MAX_BANDS : BND_MAX;
    localparam int BIW      = $clog2(BMAX);
    localparam int RB       = (MAX_BANDS < RST_BANDS) ? MAX_BANDS : RST_BANDS;
    localparam int RCAP_RAW = BANK_SAMPLES / RB;
    localparam int RCAP     = (RCAP_RAW < 1) ? 1 :
                              ((RCAP_RAW > PIX_MAX) ? PIX_MAX : RCAP_RAW);
    localparam int RP       = (RST_PIXELS < RCAP) ? RST_PIXELS : RCAP;
    localparam int RBLEN    = RP * RB;

    logic [PIX_W-1:0] cap_tab [BMAX];

    for (genvar g = 0; g < BMAX; g++) begin : g_cap
        localparam int CAP_RAW = BANK_SAMPLES / (g + 1);
        localparam int CAP_V   = (CAP_RAW < 1) ? 1 :
                                 ((CAP_RAW > PIX_MAX) ? PIX_MAX : CAP_RAW);
        assign cap_tab[g] = PIX_W'(CAP_V);
    end

    logic [PIX_W-1:0]       r_ppb, n_ppb;
    logic [BND_W-1:0]       r_bands, n_bands;
    logic                   r_dir, n_dir;
    t_cfg                   r_cfg, n_cfg;
    logic [BND_W-1:0]       beff;
    logic [PIX_W-1:0]       cap;
    logic [PIX_W-1:0]       peff;
    logic [PIX_W+BND_W-1:0] prod;

    always_comb begin
        n_ppb   = r_ppb;
        n_bands = r_bands;
        n_dir   = r_dir;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PIXELS: n_ppb   = i_cfg_wdata;
                CFG_BANDS:  n_bands = i_cfg_wdata[BND_W-1:0];
                CFG_DIR:    n_dir   = i_cfg_wdata[0];
                default: ;
            endcase
        end

        if (n_bands == '0) begin
            beff = BND_W'(1);
        end else if (n_bands > BND_W'(BMAX)) begin
            beff = BND_W'(BMAX);
        end else begin
            beff = n_bands;
        end
        cap = cap_tab[BIW'(beff - BND_W'(1))];
        if (n_ppb == '0) begin
            peff = PIX_W'(1);
        end else if (n_ppb > cap) begin
            peff = cap;
        end else begin
            peff = n_ppb;
        end
        prod = (PIX_W+BND_W)'(peff) * (PIX_W+BND_W)'(beff);

        n_cfg.blen   = BLEN_W'(prod);
        n_cfg.pixels = peff;
        n_cfg.bands  = beff;
        n_cfg.dir    = n_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppb        <= PIX_W'(RST_PIXELS);
            r_bands      <= BND_W'(RST_BANDS);
            r_dir        <= 1'b0;
            r_cfg.blen   <= BLEN_W'(RBLEN);
            r_cfg.pixels <= PIX_W'(RP);
            r_cfg.bands  <= BND_W'(RB);
            r_cfg.dir    <= 1'b0;
        end else begin
            r_ppb   <= n_ppb;
            r_bands <= n_bands;
            r_dir   <= n_dir;
            r_cfg   <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/band_interleave_reorder.sv
// ----------------------------------------------------------------------------
// band_interleave_reorder
// Ping-pong bank reorder between pixel-interleaved and band order.
//
//   channel   dir  payload                                   handshake
//   i_in      in   op, sample_in                              valid/ready
//   o_out     out  sample_out, band_out, block_end, dropped   valid/ready
//   i_cfg_*   in   idx, wdata                                 we only
//
// One request per cycle while ready is high; results leave through the output register.
// The address path (multiply, modulo by reciprocal, bank access) sets the
// latency; the single bank read and write port sets the rate.
// Synchronous reset clears counters and valid bits; banks are not cleared.
// Ready drops only when the output register holds an untaken result and
// every stage behind it is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module band_interleave_reorder import bir_pkg::*; #(
    parameter int BANK_SAMPLES = 4096,
    parameter int MAX_BANDS    = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [PIX_W-1:0] i_cfg_wdata,
    bir_in_if.sink                i_in,
    bir_out_if.source             o_out
);

    localparam int AW = $clog2(BANK_SAMPLES);
    localparam int SH = X_W + AW;
    localparam int MW = X_W + 2;
    localparam logic [63:0] MV = ((64'd1 << SH) / 64'(BANK_SAMPLES)) + 64'd1;
    localparam logic [MW-1:0] MVEC = MV[MW-1:0];

    t_cfg cfg;

    bir_cfg #(
        .BANK_SAMPLES(BANK_SAMPLES),
        .MAX_BANDS   (MAX_BANDS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    // sequencer state
    logic [PIX_W-1:0]  r_fpos;
    logic              r_fbank;
    logic [DBND_W-1:0] r_db;
    logic [DPIX_W-1:0] r_dp;
    logic              r_pend;

    // pipeline
    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tok              r_tk1, r_tk2, r_tk3, r_tk4, r_tk5;
    logic [X_W-1:0]    r_x2, r_x3, r_q3;
    logic [AW-1:0]     r_addr4;
    logic [SAMPLE_BITS-1:0] r_rd5;
    logic              en1, en2, en3, en4, en5, accept;

    logic [SAMPLE_BITS-1:0] mem [2][BANK_SAMPLES];

    // accept-time decisions
    logic              swap, pend1, emit, last, push, drop, fb;
    logic [DBND_W-1:0] db, n_db;
    logic [DPIX_W-1:0] dp, n_dp;
    logic [PIX_W-1:0]  fpos0, n_fpos;
    logic [PIX_W-1:0]  dpi;
    logic [BND_W-1:0]  dbi;
    t_tok              tok;

    always_comb begin
        swap  = (BLEN_W'(r_fpos) >= cfg.blen) && !r_pend;
        fb    = swap ? ~r_fbank : r_fbank;
        pend1 = r_pend || swap;
        db    = swap ? '0 : r_db;
        dp    = swap ? '0 : r_dp;
        fpos0 = swap ? '0 : r_fpos;
        emit  = pend1;
        dpi   = PIX_W'(dp) + PIX_W'(1);
        dbi   = BND_W'(db) + BND_W'(1);
        last  = emit && (dbi >= cfg.bands) && (dpi >= cfg.pixels);

        n_db = db;
        n_dp = dp;
        if (emit) begin
            if (last) begin
                n_db = '0;
                n_dp = '0;
            end else if (!cfg.dir) begin
                if (dpi >= cfg.pixels) begin
                    n_dp = '0;
                    n_db = db + DBND_W'(1);
                end else begin
                    n_dp = dpi[DPIX_W-1:0];
                end
            end else begin
                if (dbi >= cfg.bands) begin
                    n_db = '0;
                    n_dp = dp + DPIX_W'(1);
                end else begin
                    n_db = dbi[DBND_W-1:0];
                end
            end
        end

        push   = (t_op'(i_in.op) == OP_PUSH);
        drop   = push && (BLEN_W'(fpos0) >= cfg.blen);
        n_fpos = (push && !drop) ? (fpos0 + PIX_W'(1)) : fpos0;

        tok.emit    = emit;
        tok.drop    = drop;
        tok.last    = last;
        tok.band    = emit ? db : '0;
        if (!cfg.dir) begin
            tok.mul_a = PIX_W'(dp);
            tok.mul_m = cfg.bands;
            tok.mul_c = DPIX_W'(db);
        end else begin
            tok.mul_a = cfg.pixels;
            tok.mul_m = BND_W'(db);
            tok.mul_c = dp;
        end
        tok.rd_bank = ~fb;
        tok.wr_en   = push && !drop;
        tok.wr_bank = fb;
        tok.wr_pos  = fpos0;
        tok.wr_data = i_in.sample_in;
    end

    // stall chain from the output register back to the input
    assign en5    = !(r_v5 && (r_tk5.emit || r_tk5.drop)) || o_out.ready;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign accept = i_in.valid && en1;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpos  <= '0;
            r_fbank <= 1'b0;
            r_db    <= '0;
            r_dp    <= '0;
            r_pend  <= 1'b0;
        end else if (accept) begin
            r_fpos  <= n_fpos;
            r_fbank <= fb;
            r_db    <= n_db;
            r_dp    <= n_dp;
            r_pend  <= emit && !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // address path: offset, quotient by reciprocal, remainder
    logic [PIX_W+BND_W-1:0] prod1;
    logic [X_W+MW-1:0]      qprod;
    logic [X_W-1:0]         qbank;

    always_comb begin
        prod1 = (PIX_W+BND_W)'(r_tk1.mul_a) * (PIX_W+BND_W)'(r_tk1.mul_m);
        qprod = (X_W+MW)'(r_x2) * (X_W+MW)'(MVEC);
        qbank = r_q3 * X_W'(BANK_SAMPLES);
    end

    always_ff @(posedge i_clk) begin
        if (en1 && accept) begin
            r_tk1 <= tok;
        end
        if (en2) begin
            r_tk2 <= r_tk1;
            r_x2  <= X_W'(prod1) + X_W'(r_tk1.mul_c);
        end
        if (en3) begin
            r_tk3 <= r_tk2;
            r_x3  <= r_x2;
            r_q3  <= X_W'(qprod >> SH);
        end
        if (en4) begin
            r_tk4   <= r_tk3;
            r_addr4 <= AW'(r_x3 - qbank);
        end
        if (en5) begin
            r_tk5 <= r_tk4;
        end
    end

    // sample banks: read the draining bank, write the filling bank
    always_ff @(posedge i_clk) begin
        if (en5 && r_v4) begin
            r_rd5 <= mem[r_tk4.rd_bank][r_addr4];
            if (r_tk4.wr_en) begin
                mem[r_tk4.wr_bank][AW'(r_tk4.wr_pos)] <=
                    SAMPLE_BITS'(r_tk4.wr_data);
            end
        end
    end

    assign o_out.valid      = r_v5 && (r_tk5.emit || r_tk5.drop);
    assign o_out.sample_out = r_tk5.emit ? SMP_W'(r_rd5) : '0;
    assign o_out.band_out   = r_tk5.band;
    assign o_out.block_end  = r_tk5.last;
    assign o_out.dropped    = r_tk5.drop;

`ifndef SYNTHESIS
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && en5 && r_tk4.wr_en && r_tk4.emit |-> r_tk4.wr_bank != r_tk4.rd_bank)
        else $error("read and write hit the same bank");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> ({1'b0, r_addr4} < (AW+1)'(BANK_SAMPLES)))
        else $error("bank address out of range");

    a_drop_nowrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_tk1.drop |-> !r_tk1.wr_en && r_tk1.emit)
        else $error("dropped push still writes or comes without a sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> r_v5 && $stable(r_tk5) && $stable(r_rd5))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for band_interleave_reorder. A scoreboard class mirrors
// the ping-pong banks, fill and drain counters and size clamping, predicts
// every output request from the accepted input requests and compares it field
// by field. Stimulus covers sample extremes, both directions, clamped sizes,
// an oversized block cut short by a smaller one, shrinking the block while a
// drain is under way, and random phases with idle gaps on both channels and
// a long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import bir_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int MAX_GAP        = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 98;
    localparam int CLAMP_PUSHES   = 40;

    typedef struct packed {
        logic [SMP_W-1:0]  smp;
        logic [DBND_W-1:0] band;
        logic              last;
        logic              drop;
    } reorder_result_t;

    class reorder_scoreboard;
        localparam int DEPTH       = 4096;
        localparam int BANDS_LIMIT = 16;
        localparam int MAX_REPORTS = 10;

        logic [SMP_W-1:0] bank_mem [0:2*DEPTH-1];
        int unsigned fill_pos;
        bit          fill_sel;
        int unsigned rd_band;
        int unsigned rd_pixel;
        bit          draining;
        int unsigned pixels_reg;
        int unsigned bands_reg;
        bit          dir_reg;
        reorder_result_t expected_q [$];
        int requests;
        int checked;
        int mismatches;
        int drops;
        int block_ends;

        function new();
            fill_pos   = 0;
            fill_sel   = 1'b0;
            rd_band    = 0;
            rd_pixel   = 0;
            draining   = 1'b0;
            pixels_reg = RST_PIXELS;
            bands_reg  = RST_BANDS;
            dir_reg    = 1'b0;
            foreach (bank_mem[i]) bank_mem[i] = '0;
        endfunction

        function int unsigned clamp_bands(int unsigned v);
            if (v < 1) return 1;
            if (v > BANDS_LIMIT) return BANDS_LIMIT;
            return v;
        endfunction

        function int unsigned clamp_pixels(int unsigned v, int unsigned nb);
            int unsigned cap;
            cap = DEPTH / nb;
            if (cap < 1) cap = 1;
            if (v < 1) v = 1;
            if (v > cap) v = cap;
            return v;
        endfunction

        function int unsigned bands_now();
            return clamp_bands(bands_reg);
        endfunction

        function int unsigned pixels_now();
            return clamp_pixels(pixels_reg, bands_now());
        endfunction

        // shrinking both sizes keeps a running drain inside written entries
        function bit change_is_safe(int unsigned p, int unsigned b);
            int unsigned nb;
            nb = clamp_bands(b);
            if (!draining) return 1'b1;
            return nb <= bands_now() && clamp_pixels(p, nb) <= pixels_now();
        endfunction

        function void set_register(t_cfg_idx idx, int unsigned v);
            case (idx)
                CFG_PIXELS: pixels_reg = v & 'h1FFF;
                CFG_BANDS:  bands_reg  = v & 'h1F;
                CFG_DIR:    dir_reg    = v[0];
                default: ;
            endcase
        endfunction

        function int unsigned read_addr(int unsigned np, int unsigned nb);
            if (dir_reg == 1'b0) return (rd_pixel * nb + rd_band) % DEPTH;
            return (rd_band * np + rd_pixel) % DEPTH;
        endfunction

        function void note_request(t_op op, logic [SMP_W-1:0] smp);
            int unsigned nb, np, blen, addr;
            bit emitted, dropped, last;
            reorder_result_t r;
            nb = bands_now();
            np = pixels_now();
            blen = np * nb;
            emitted = 1'b0;
            dropped = 1'b0;
            r = '0;
            requests++;
            if (fill_pos >= blen && !draining) begin
                fill_sel = ~fill_sel;
                fill_pos = 0;
                rd_band  = 0;
                rd_pixel = 0;
                draining = 1'b1;
            end
            if (draining) begin
                addr = read_addr(np, nb);
                r.smp  = bank_mem[(fill_sel ? 0 : DEPTH) + addr];
                r.band = DBND_W'(rd_band);
                last = (rd_band + 1 >= nb) && (rd_pixel + 1 >= np);
                r.last = last;
                emitted = 1'b1;
                if (last) begin
                    draining = 1'b0;
                    rd_band  = 0;
                    rd_pixel = 0;
                end else if (dir_reg == 1'b0) begin
                    rd_pixel++;
                    if (rd_pixel >= np) begin
                        rd_pixel = 0;
                        rd_band++;
                    end
                end else begin
                    rd_band++;
                    if (rd_band >= nb) begin
                        rd_band = 0;
                        rd_pixel++;
                    end
                end
                rd_band  &= 'hF;
                rd_pixel &= 'hFFF;
            end
            if (op == OP_PUSH) begin
                if (fill_pos >= blen) begin
                    dropped = 1'b1;
                end else begin
                    bank_mem[(fill_sel ? DEPTH : 0) + fill_pos % DEPTH] = smp;
                    fill_pos = (fill_pos + 1) & 'h1FFF;
                end
            end
            r.drop = dropped;
            if (emitted || dropped) expected_q.push_back(r);
        endfunction

        function void check_result(logic [SMP_W-1:0] smp, logic [DBND_W-1:0] band,
                                   logic last, logic drop);
            reorder_result_t want;
            checked++;
            if (drop === 1'b1) drops++;
            if (last === 1'b1) block_ends++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: sample %h band %0d end %b drop %b, none expected",
                             checked, smp, band, last, drop);
                return;
            end
            want = expected_q.pop_front();
            if (want.smp !== smp || want.band !== band || want.last !== last
                    || want.drop !== drop) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                             checked, want.smp, want.band, want.last, want.drop,
                             smp, band, last, drop);
            end
        endfunction

        function int failures();
            return mismatches + expected_q.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_idx;
    logic [PIX_W-1:0] i_cfg_wdata;

    bir_in_if  in_if ();
    bir_out_if out_if ();

    reorder_scoreboard sb = new();

    bit tx_gaps_on;
    bit rx_gaps_on;
    int hold_request;
    int settings_used;
    int cycle_count;
    logic [SMP_W-1:0] edge_samples [6] = '{16'h0000, 16'hFFFF, 16'h0001,
                                           16'h8000, 16'h5555, 16'hAAAA};

    band_interleave_reorder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // called right after a rising edge; returns at the edge that takes the request
    task automatic send_request(input t_op op, input logic [SMP_W-1:0] smp);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.sample_in <= smp;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        sb.note_request(op, smp);
    endtask

    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reconfigure(input int unsigned p, input int unsigned b, input bit d);
        t_cfg_idx    regs [3];
        int unsigned vals [3];
        regs = '{CFG_PIXELS, CFG_BANDS, CFG_DIR};
        vals = '{p, b, d};
        settle_block();
        if (!sb.change_is_safe(p, b)) begin
            // finish the running drain before growing the block
            while (sb.draining) send_request(OP_DRAIN, SMP_W'($urandom));
            settle_block();
        end
        foreach (regs[i]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= regs[i];
            i_cfg_wdata <= PIX_W'(vals[i]);
            @(posedge i_clk);
            sb.set_register(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : result_sink
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            sb.check_result(out_if.sample_out, out_if.band_out, out_if.block_end,
                            out_if.dropped);
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, sb.expected_q.size());
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned p, b;
        bit d;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_PIXELS;
        i_cfg_wdata     <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_PUSH;
        in_if.sample_in <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample extremes, then shrink mid-drain so pushes get dropped
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        reconfigure(2, 3, 1'b0);
        foreach (edge_samples[i]) send_request(OP_PUSH, edge_samples[i]);
        repeat (9) send_request(OP_PUSH, SMP_W'($urandom));
        reconfigure(1, 2, 1'b1);
        repeat (2) send_request(OP_PUSH, SMP_W'($urandom));
        repeat (2) send_request(OP_DRAIN, SMP_W'($urandom));
        // zero sizes clamp to a one-sample block
        reconfigure(0, 0, 1'b0);
        repeat (3) send_request(OP_PUSH, SMP_W'($urandom));

        // both sizes above their limits, then a smaller block ends the fill early
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        reconfigure(PIX_MAX, BND_MAX, 1'b1);
        repeat (CLAMP_PUSHES) send_request(OP_PUSH, SMP_W'($urandom));
        reconfigure(2, BND_MAX, 1'b1);
        repeat (CLAMP_PUSHES) send_request(OP_PUSH, SMP_W'($urandom));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            d = 1'($urandom_range(0, 1));
            if (ph == 2) begin
                p = 8;
                b = 4;
            end else if ($urandom_range(0, 2) == 0) begin
                p = $urandom_range(1, sb.pixels_now());
                b = $urandom_range(1, sb.bands_now());
            end else begin
                case ($urandom_range(0, 5))
                    0:       p = $urandom_range(0, PIX_MAX);
                    1:       p = $urandom_range(17, 300);
                    default: p = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 5))
                    0:       b = $urandom_range(17, BND_MAX);
                    1:       b = 0;
                    default: b = $urandom_range(1, 16);
                endcase
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            reconfigure(p, b, d);
            if (ph == 2) begin
                tx_gaps_on   = 1'b0;
                hold_request = LONG_HOLD;
            end
            repeat (PHASE_REQUESTS)
                send_request(($urandom_range(0, 7) == 0) ? OP_DRAIN : OP_PUSH,
                             SMP_W'($urandom));
        end

        settle_block();
        $display("%0d input requests over %0d register settings, both directions",
                 sb.requests, settings_used);
        $display("%0d samples checked: %0d block ends, %0d dropped pushes, %0d mismatches",
                 sb.checked, sb.block_ends, sb.drops, sb.mismatches);
        if (sb.failures() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
